>>> rtl/hqp_pkg.sv
// ----------------------------------------------------------------------------
// hqp_pkg
// Shared types and codes for the Hildreth dual QP solver.
// ----------------------------------------------------------------------------
`default_nettype none
package hqp_pkg;
    localparam logic [1:0] OP_LOAD_P = 2'd0;
    localparam logic [1:0] OP_LOAD_D = 2'd1;
    localparam logic [1:0] OP_SOLVE  = 2'd2;

    localparam logic [1:0] REG_ACTIVE_SIZE = 2'd0;
    localparam logic [1:0] REG_MAX_SWEEPS  = 2'd1;
    localparam logic [1:0] REG_TOLERANCE   = 2'd2;

    typedef struct packed {
        logic [1:0]  operation;
        logic [4:0]  row_index;
        logic [4:0]  col_index;
        logic signed [31:0] entry_value;
    } t_in_item;

    typedef struct packed {
        logic [4:0]  multiplier_index;
        logic [30:0] multiplier_value;
        logic        last_multiplier;
        logic [7:0]  sweeps_used;
        logic        converged;
        logic        zero_diagonal;
    } t_out_item;

    typedef struct packed {
        logic [1:0]  index;
        logic [31:0] data;
    } t_cfg_item;

    // divider handshake between sequencer and divider
    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [63:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [63:0] quotient;
    } t_div_rsp;
endpackage
`default_nettype wire

>>> rtl/hqp_if.sv
// ----------------------------------------------------------------------------
// hqp_in_if / hqp_out_if / hqp_cfg_if
// Valid/ready channels of the solver.
// ----------------------------------------------------------------------------
`default_nettype none
interface hqp_in_if;
    logic valid;
    logic ready;
    hqp_pkg::t_in_item payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface hqp_out_if;
    logic valid;
    logic ready;
    hqp_pkg::t_out_item payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface hqp_cfg_if;
    logic valid;
    logic ready;
    hqp_pkg::t_cfg_item payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

>>> rtl/hildreth_qp_dual_solver_core.sv
// ----------------------------------------------------------------------------
// hildreth_qp_dual_solver_core
// Hildreth Gauss-Seidel sweeps over dual multipliers with one shared MAC.
// ----------------------------------------------------------------------------
//  channel  dir  payload
//  in_ch    in   operation, row_index, col_index, entry_value
//  out_ch   out  multiplier_index/value, last, sweeps, converged, zero_diag
//  cfg_ch   in   index (0 size, 1 sweeps, 2 tolerance), data
//
// A solve clears n multipliers, then each row fetches diagonal and offset
// (S_ROW, S_RD), takes each Hessian entry through S_MUL, S_ACC and S_UPD over a
// registered memory port, runs the shared 64-step divider only when the update
// is positive, and then updates the multiplier (S_SQ, S_SWEEP).
// Results stream out one per cycle while the sink is ready; the input is not
// ready until the last one is taken. Reset is synchronous; stores are
// undefined until loaded.
`default_nettype none
module hildreth_qp_dual_solver_core #(
    parameter int MAX_CONSTRAINTS = 32,
    parameter int VALUE_WIDTH     = 32
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    hqp_in_if.sink    in_ch,
    hqp_out_if.source out_ch,
    hqp_cfg_if.sink   cfg_ch
);
    import hqp_pkg::*;

    localparam int IW = $clog2(MAX_CONSTRAINTS);
    localparam int NW = IW + 1;
    localparam int N_LIM = (MAX_CONSTRAINTS < 32) ? MAX_CONSTRAINTS : 32;
    localparam logic signed [63:0] VAL_HI = (64'sd1 <<< (VALUE_WIDTH - 1)) - 64'sd1;
    localparam logic signed [63:0] VAL_LO = -VAL_HI - 64'sd1;
    localparam logic signed [63:0] S64_MAX = 64'sh7FFFFFFFFFFFFFFF;
    localparam logic signed [63:0] S64_MIN = 64'sh8000000000000000;

    localparam logic [3:0] S_IDLE = 4'd0, S_ROW = 4'd1, S_RD = 4'd2, S_MUL = 4'd3,
                           S_ACC = 4'd4, S_DIV = 4'd5, S_UPD = 4'd6, S_SQ = 4'd7,
                           S_SWEEP = 4'd8, S_OUT = 4'd9, S_CLR = 4'd10;

    logic signed [VALUE_WIDTH-1:0] mem_p [1 << (2*IW)];
    logic signed [VALUE_WIDTH-1:0] mem_d [1 << IW];
    logic signed [VALUE_WIDTH-1:0] r_lam [1 << IW];

    logic [3:0]  r_state;
    logic [5:0]  r_size;
    logic [7:0]  r_maxsw;
    logic [31:0] r_tol;
    logic [IW-1:0] r_i, r_j;
    logic [NW-1:0] r_n;
    logic [7:0]  r_sweeps;
    logic        r_conv, r_zdiag;
    logic signed [63:0] r_w, r_prod;
    logic signed [VALUE_WIDTH-1:0] r_pd, r_dd, r_diag, r_lnew;
    logic [63:0] r_chg, r_sq;
    logic        r_ovf;
    logic        r_jlast;
    t_div_req    w_req;
    t_div_rsp    w_rsp;

    logic signed [63:0] w_ent;
    logic signed [VALUE_WIDTH-1:0] w_ent_sat;
    logic [NW-1:0] w_n;
    logic [2*IW-1:0] w_addr_ld, w_addr_rd;
    logic [63:0] w_mp, w_ml, w_prod_mag;
    logic [127:0] w_full;
    logic signed [64:0] w_sum;
    logic signed [63:0] w_lam_ext, w_prev_ext;
    logic [63:0] w_diff, w_wmag, w_dmag;
    logic [127:0] w_sq_full;
    logic [64:0] w_chg_sum;

    function automatic logic signed [63:0] w_sum_sat(input logic signed [64:0] s);
        if (s > 65'(S64_MAX)) return S64_MAX;
        else if (s < 65'(S64_MIN)) return S64_MIN;
        else return s[63:0];
    endfunction

    assign in_ch.ready  = (r_state == S_IDLE);
    assign cfg_ch.ready = 1'b1;

    assign w_ent = 64'(in_ch.payload.entry_value);
    always_comb begin
        priority if (w_ent > VAL_HI) w_ent_sat = VALUE_WIDTH'(VAL_HI);
        else if (w_ent < VAL_LO) w_ent_sat = VALUE_WIDTH'(VAL_LO);
        else w_ent_sat = VALUE_WIDTH'(w_ent);
    end

    always_comb begin
        w_n = (r_size == 6'd0) ? NW'(1) : NW'(r_size);
        if (32'(r_size) > N_LIM) w_n = NW'(N_LIM);
    end

    assign w_addr_ld = {IW'(in_ch.payload.row_index), IW'(in_ch.payload.col_index)};
    // the diagonal is fetched while a row starts
    assign w_addr_rd = (r_state == S_ROW) ? {r_i, r_i} : {r_i, r_j};

    // memories
    always_ff @(posedge i_clk) begin
        if (in_ch.valid && in_ch.ready && in_ch.payload.operation == OP_LOAD_P &&
            32'(in_ch.payload.row_index) < MAX_CONSTRAINTS &&
            32'(in_ch.payload.col_index) < MAX_CONSTRAINTS)
            mem_p[w_addr_ld] <= w_ent_sat;
        if (in_ch.valid && in_ch.ready && in_ch.payload.operation == OP_LOAD_D &&
            32'(in_ch.payload.row_index) < MAX_CONSTRAINTS)
            mem_d[IW'(in_ch.payload.row_index)] <= w_ent_sat;
        r_pd <= mem_p[w_addr_rd];
        r_dd <= mem_d[r_i];
    end

    // MAC datapath
    assign w_mp = r_pd[VALUE_WIDTH-1] ? 64'(-64'(r_pd)) : 64'(r_pd);
    assign w_ml = 64'(r_lam[r_j]);
    assign w_full = 128'(w_mp[VALUE_WIDTH-1:0]) * 128'(w_ml[VALUE_WIDTH-1:0]);
    assign w_prod_mag = (w_full > 128'(S64_MAX)) ? 64'(S64_MAX) : w_full[63:0];
    assign w_sum = 65'(r_w) + 65'(r_prod);

    assign w_wmag = r_w[63] ? 64'(-r_w) : 64'(r_w);
    assign w_dmag = r_diag[VALUE_WIDTH-1] ? 64'(-64'(r_diag)) : 64'(r_diag);
    assign w_lam_ext = 64'(r_lnew);
    assign w_prev_ext = 64'(r_lam[r_i]);
    assign w_diff = (w_lam_ext > w_prev_ext) ? 64'(w_lam_ext - w_prev_ext)
                                             : 64'(w_prev_ext - w_lam_ext);
    assign w_sq_full = 128'(w_diff[VALUE_WIDTH-1:0]) * 128'(w_diff[VALUE_WIDTH-1:0]);
    assign w_chg_sum = 65'(r_chg) + 65'(r_sq);

    always_comb begin
        w_req.start    = 1'b0;
        w_req.dividend = w_wmag;
        w_req.divisor  = w_dmag;
        if (r_state == S_DIV && r_ovf) w_req.start = 1'b1;
    end

    hqp_divider u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_req),
        .o_rsp  (w_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_size  <= 6'd32;
            r_maxsw <= 8'd40;
            r_tol   <= 32'd1;
            r_ovf   <= 1'b0;
        end else begin
            if (cfg_ch.valid) begin
                unique case (cfg_ch.payload.index)
                    REG_ACTIVE_SIZE: r_size  <= cfg_ch.payload.data[5:0];
                    REG_MAX_SWEEPS:  r_maxsw <= cfg_ch.payload.data[7:0];
                    REG_TOLERANCE:   r_tol   <= cfg_ch.payload.data;
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_ch.valid && in_ch.payload.operation == OP_SOLVE) begin
                        r_n      <= w_n;
                        r_i      <= '0;
                        r_sweeps <= 8'd0;
                        r_conv   <= 1'b0;
                        r_zdiag  <= 1'b0;
                        r_state  <= S_CLR;
                    end
                end
                S_CLR: begin
                    // clear multipliers one per cycle
                    r_lam[r_i] <= '0;
                    if (NW'(r_i) == r_n - NW'(1)) begin
                        r_i     <= '0;
                        r_chg   <= 64'd0;
                        r_state <= S_ROW;
                    end else r_i <= r_i + IW'(1);
                end
                S_ROW: begin
                    r_j     <= r_i;
                    r_state <= S_RD;
                end
                S_RD: begin
                    // diagonal and offset arrive
                    r_diag  <= r_pd;
                    r_w     <= 64'(r_dd) <<< 16;
                    r_j     <= '0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    // P[i][j] is on the read port; data is ready in S_ACC
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_prod  <= r_pd[VALUE_WIDTH-1] ? -w_prod_mag : w_prod_mag;
                    r_jlast <= (NW'(r_j) == r_n - NW'(1));
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    if (r_j != r_i) r_w <= w_sum_sat(w_sum);
                    if (r_jlast) begin
                        r_state <= S_DIV;
                        r_ovf   <= 1'b1;
                    end else begin
                        r_j     <= r_j + IW'(1);
                        r_state <= S_MUL;
                    end
                end
                S_DIV: begin
                    r_ovf <= 1'b0;
                    if (r_ovf) begin
                        if (r_diag == '0) r_zdiag <= 1'b1;
                        if (r_diag == '0 || !((r_w < 0 && r_diag > 0) ||
                                              (r_w > 0 && r_diag < 0))) begin
                            r_lnew  <= '0;
                            r_state <= S_SQ;
                        end
                    end else if (w_rsp.done) begin
                        r_lnew  <= (w_rsp.quotient > 64'(VAL_HI)) ? VALUE_WIDTH'(VAL_HI)
                                                                 : VALUE_WIDTH'(w_rsp.quotient);
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    r_sq       <= w_sq_full[63:0];
                    r_lam[r_i] <= r_lnew;
                    r_state    <= S_SWEEP;
                end
                S_SWEEP: begin
                    if (NW'(r_i) == r_n - NW'(1)) begin
                        r_sweeps <= r_sweeps + 8'd1;
                        r_i      <= '0;
                        r_chg    <= 64'd0;
                        if (w_chg_sum[64] == 1'b0 && w_chg_sum[63:0] < 64'(r_tol)) begin
                            r_conv  <= 1'b1;
                            r_state <= S_OUT;
                        end else if (r_sweeps + 8'd1 >=
                                     ((r_maxsw == 8'd0) ? 8'd1 : r_maxsw)) begin
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_ROW;
                        end
                    end else begin
                        r_chg   <= w_chg_sum[64] ? 64'hFFFFFFFFFFFFFFFF : w_chg_sum[63:0];
                        r_i     <= r_i + IW'(1);
                        r_state <= S_ROW;
                    end
                end
                S_OUT: begin
                    if (out_ch.ready) begin
                        if (NW'(r_i) == r_n - NW'(1)) r_state <= S_IDLE;
                        else r_i <= r_i + IW'(1);
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    logic [63:0] w_out_v;
    assign w_out_v = 64'(r_lam[r_i]);
    assign out_ch.valid = (r_state == S_OUT);
    assign out_ch.payload.multiplier_index = 5'(r_i);
    assign out_ch.payload.multiplier_value =
        (w_out_v > 64'h7FFFFFFF) ? 31'h7FFFFFFF : w_out_v[30:0];
    assign out_ch.payload.last_multiplier = (NW'(r_i) == r_n - NW'(1));
    assign out_ch.payload.sweeps_used = r_sweeps;
    assign out_ch.payload.converged = r_conv;
    assign out_ch.payload.zero_diagonal = r_zdiag;
endmodule
`default_nettype wire

>>> rtl/hqp_divider.sv
// ----------------------------------------------------------------------------
// hqp_divider
// Unsigned 64 by 64 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module hqp_divider (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire hqp_pkg::t_div_req i_req,
    output hqp_pkg::t_div_rsp      o_rsp
);
    import hqp_pkg::*;

    logic [63:0] r_rem, r_quo, r_div;
    logic [6:0]  r_cnt;
    logic        r_busy, r_done;
    logic [64:0] w_trial;

    assign w_trial = {r_rem, r_quo[63]} - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'd0;
                r_rem  <= 64'd0;
                r_quo  <= i_req.dividend;
                r_div  <= i_req.divisor;
            end else if (r_busy) begin
                if (!w_trial[64]) begin
                    r_rem <= w_trial[63:0];
                    r_quo <= {r_quo[62:0], 1'b1};
                end else begin
                    r_rem <= {r_rem[62:0], r_quo[63]};
                    r_quo <= {r_quo[62:0], 1'b0};
                end
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;
endmodule
`default_nettype wire

>>> tb/sv/hildreth_qp_dual_solver_core_test.sv
// ----------------------------------------------------------------------------
// hildreth_qp_dual_solver_core_test
// Loads Hessian and offset entries, runs solves under several register
// settings and random handshake idling, and checks every reported multiplier
// against an in-bench Hildreth predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module hildreth_qp_dual_solver_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import hqp_pkg::*;

    class solver_scoreboard;
        localparam longint MAXL = 64'sh7FFF_FFFF_FFFF_FFFF;
        localparam longint MINL = -MAXL - 1;
        localparam longint unsigned MAXU = 64'hFFFF_FFFF_FFFF_FFFF;
        localparam longint VHI = 64'sh7FFF_FFFF;

        longint hessian [32][32];
        longint offsets [32];
        logic [5:0]  active_size;
        logic [7:0]  sweep_limit;
        logic [31:0] tol_sq;
        t_out_item   expected_multipliers [$];
        int          errors;

        function new();
            foreach (hessian[i, j]) hessian[i][j] = 0;
            foreach (offsets[i]) offsets[i] = 0;
            active_size = 6'd32;
            sweep_limit = 8'd40;
            tol_sq = 32'd1;
            errors = 0;
        endfunction

        function void write_reg(t_cfg_item c);
            case (c.index)
                REG_ACTIVE_SIZE: active_size = c.data[5:0];
                REG_MAX_SWEEPS:  sweep_limit = c.data[7:0];
                REG_TOLERANCE:   tol_sq = c.data;
                default: ;
            endcase
        endfunction

        function longint unsigned mag(longint a);
            return a < 0 ? 64'd0 - longint'(a) : longint'(a);
        endfunction

        function longint sat_add(longint a, longint b);
            if (b > 0 && a > MAXL - b) return MAXL;
            if (b < 0 && a < MINL - b) return MINL;
            return a + b;
        endfunction

        function longint sat_mul(longint p, longint lam);
            longint unsigned mp, ml, prod;
            mp = mag(p);
            ml = lam;
            if (mp == 0 || ml == 0) return 0;
            if (ml > longint'(MAXL) / mp) prod = MAXL;
            else prod = mp * ml;
            return p < 0 ? -longint'(prod) : longint'(prod);
        endfunction

        function void run_solve();
            int n, limit, sweeps;
            bit conv, zdiag, pos;
            longint lam_vec [32];
            longint diag, w, lam, prev;
            longint unsigned acc, diff, sq, q;
            t_out_item r;
            n = (active_size == 0) ? 1 : active_size;
            if (n > 32) n = 32;
            limit = (sweep_limit == 0) ? 1 : sweep_limit;
            sweeps = 0;
            conv = 0;
            zdiag = 0;
            foreach (lam_vec[i]) lam_vec[i] = 0;
            while (sweeps < limit) begin
                acc = 0;
                for (int i = 0; i < n; i++) begin
                    diag = hessian[i][i];
                    w = offsets[i] * 65536;
                    lam = 0;
                    prev = lam_vec[i];
                    for (int j = 0; j < n; j++)
                        if (j != i) w = sat_add(w, sat_mul(hessian[i][j], lam_vec[j]));
                    if (diag == 0) begin
                        zdiag = 1;
                    end else begin
                        pos = (w < 0 && diag > 0) || (w > 0 && diag < 0);
                        if (pos) begin
                            q = mag(w) / mag(diag);
                            lam = (q > VHI) ? VHI : longint'(q);
                        end
                    end
                    lam_vec[i] = lam;
                    diff = (lam > prev) ? longint'(lam - prev) : longint'(prev - lam);
                    if (diff != 0 && diff > MAXU / diff) sq = MAXU;
                    else sq = diff * diff;
                    acc = (acc > MAXU - sq) ? MAXU : acc + sq;
                end
                sweeps++;
                if (acc < {32'd0, tol_sq}) begin
                    conv = 1;
                    break;
                end
            end
            for (int i = 0; i < n; i++) begin
                r.multiplier_index = i[4:0];
                r.multiplier_value = lam_vec[i][30:0];
                r.last_multiplier  = (i == n - 1);
                r.sweeps_used      = sweeps[7:0];
                r.converged        = conv;
                r.zero_diagonal    = zdiag;
                expected_multipliers.push_back(r);
            end
        endfunction

        function void note_request(t_in_item it);
            case (it.operation)
                OP_LOAD_P: hessian[it.row_index][it.col_index] =
                               longint'($signed(it.entry_value));
                OP_LOAD_D: offsets[it.row_index] = longint'($signed(it.entry_value));
                OP_SOLVE:  run_solve();
                default: ;
            endcase
        endfunction

        function void check_result(t_out_item got);
            t_out_item exp_r;
            if (expected_multipliers.size() == 0) begin
                $error("multiplier %0d reported with none pending", got.multiplier_index);
                errors++;
                return;
            end
            exp_r = expected_multipliers.pop_front();
            if (got.multiplier_index != exp_r.multiplier_index) begin
                $error("multiplier_index exp %0d got %0d", exp_r.multiplier_index,
                       got.multiplier_index);
                errors++;
            end
            if (got.multiplier_value != exp_r.multiplier_value) begin
                $error("multiplier_value exp %0h got %0h", exp_r.multiplier_value,
                       got.multiplier_value);
                errors++;
            end
            if (got.last_multiplier != exp_r.last_multiplier) begin
                $error("last_multiplier exp %0b got %0b", exp_r.last_multiplier,
                       got.last_multiplier);
                errors++;
            end
            if (got.sweeps_used != exp_r.sweeps_used) begin
                $error("sweeps_used exp %0d got %0d", exp_r.sweeps_used, got.sweeps_used);
                errors++;
            end
            if (got.converged != exp_r.converged) begin
                $error("converged exp %0b got %0b", exp_r.converged, got.converged);
                errors++;
            end
            if (got.zero_diagonal != exp_r.zero_diagonal) begin
                $error("zero_diagonal exp %0b got %0b", exp_r.zero_diagonal,
                       got.zero_diagonal);
                errors++;
            end
        endfunction
    endclass

    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   tx_idle_pct = 0;
    int   rx_idle_pct = 0;
    bit   rx_hold = 0;
    bit   hold_armed = 0;

    hqp_in_if  in_ch ();
    hqp_out_if out_ch ();
    hqp_cfg_if cfg_ch ();

    solver_scoreboard sb = new();

    hildreth_qp_dual_solver_core dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        in_ch.valid   <= 1'b0;
        in_ch.payload <= '0;
        cfg_ch.valid  <= 1'b0;
        cfg_ch.payload <= '0;
    end

    always @(posedge i_clk) begin
        out_ch.ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) sb.note_request(in_ch.payload);
            if (cfg_ch.valid && cfg_ch.ready) sb.write_reg(cfg_ch.payload);
            if (out_ch.valid && out_ch.ready) sb.check_result(out_ch.payload);
        end
    end

    // long receiver stall while results are waiting, so the block backs up
    initial begin
        wait (hold_armed);
        do @(posedge i_clk); while (!out_ch.valid);
        rx_hold = 1;
        repeat (600) @(posedge i_clk);
        rx_hold = 0;
    end

    initial begin
        #100_000_000;
        $display("TB_ERROR");
        $finish;
    end

    task automatic send_request(logic [1:0] op, int row, int col, logic [31:0] value);
        t_in_item it;
        it.operation = op;
        it.row_index = row[4:0];
        it.col_index = col[4:0];
        it.entry_value = value;
        in_ch.valid <= 1'b1;
        in_ch.payload <= it;
        do @(posedge i_clk); while (!in_ch.ready);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_multipliers.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        t_cfg_item c;
        c.index = idx;
        c.data = data;
        cfg_ch.valid <= 1'b1;
        cfg_ch.payload <= c;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_entry(bit diag, bit offset);
        int v;
        if ($urandom_range(99) < 8) return $urandom;
        if (offset) return -$urandom_range(0, 6 << 16) + $urandom_range(0, 1 << 16);
        if (diag) begin
            if ($urandom_range(99) < 4) return 32'd0;
            v = ($urandom_range(1, 8) << 16) + $urandom_range(0, 16'hFFFF);
            return ($urandom_range(9) == 0) ? -v : v;
        end
        return $urandom_range(0, 16'hFFFF) - 32'sh8000;
    endfunction

    // full load of an n by n problem, optional stray requests, then a solve
    task automatic run_problem(int n);
        for (int i = 0; i < n; i++) begin
            for (int j = 0; j < n; j++) begin
                send_request(OP_LOAD_P, i, j, pick_entry(i == j, 0));
                if ($urandom_range(99) < 3) send_request(OP_UNUSED, $urandom, $urandom, $urandom);
            end
            send_request(OP_LOAD_D, i, $urandom, pick_entry(0, 1));
        end
        if ($urandom_range(99) < 15)
            send_request(OP_LOAD_P, $urandom_range(0, n - 1), $urandom_range(0, n - 1),
                         $urandom);
        send_request(OP_SOLVE, $urandom, $urandom, $urandom);
    endtask

    initial begin
        int n;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // size and sweep limit of zero act as one; zero diagonal; unused opcode
        write_reg(REG_ACTIVE_SIZE, 32'd0);
        write_reg(REG_MAX_SWEEPS, 32'd0);
        write_reg(REG_TOLERANCE, 32'd0);
        send_request(OP_LOAD_P, 0, 0, 32'd0);
        send_request(OP_LOAD_D, 0, 0, 32'd5 << 16);
        send_request(OP_SOLVE, 31, 31, 32'hFFFF_FFFF);
        send_request(OP_UNUSED, 0, 0, 32'd0);
        send_request(OP_LOAD_P, 31, 31, 32'h7FFF_FFFF);
        send_request(OP_LOAD_D, 31, 0, 32'h8000_0000);
        send_request(OP_LOAD_P, 0, 0, 32'h0001_0000);
        send_request(OP_LOAD_D, 0, 0, -(32'd3 << 16));
        send_request(OP_SOLVE, 0, 0, 32'd0);
        wait_idle();
        write_reg(REG_TOLERANCE, 32'hFFFF_FFFF);
        write_reg(REG_MAX_SWEEPS, 32'd255);
        // saturating quotient, then a negative diagonal
        send_request(OP_LOAD_P, 0, 0, 32'd1);
        send_request(OP_LOAD_D, 0, 0, 32'h8000_0000);
        send_request(OP_SOLVE, 0, 0, 32'd0);
        send_request(OP_LOAD_P, 0, 0, -32'sh0001_0000);
        send_request(OP_LOAD_D, 0, 0, 32'd7 << 16);
        send_request(OP_SOLVE, 0, 0, 32'd0);
        wait_idle();

        for (int s = 0; s < 27; s++) begin
            if (s == 0) begin
                tx_idle_pct = 18;
                rx_idle_pct = 88;
            end else if (s == 9) begin
                tx_idle_pct = 88;
                rx_idle_pct = 18;
            end else if (s == 18) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
                hold_armed = 1;
            end
            if (s % 3 == 0) begin
                wait_idle();
                n = $urandom_range(1, 5);
                write_reg(REG_ACTIVE_SIZE, n);
                write_reg(REG_MAX_SWEEPS, (s == 3) ? 255 : $urandom_range(1, 40));
                case ($urandom_range(3))
                    0: write_reg(REG_TOLERANCE, 32'd0);
                    1: write_reg(REG_TOLERANCE, $urandom);
                    default: write_reg(REG_TOLERANCE, $urandom_range(1, 1 << 20));
                endcase
            end
            run_problem(n);
        end
        wait_idle();

        if (sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

`default_nettype wire
